// File: sv/lgs_pkg.sv
package lgs_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int LEN_FIELD_W = 9;
    localparam int CNT_FIELD_W = 10;

    localparam int MIN_DIM       = 3;
    localparam int LEN_RESET     = 150;
    localparam int CNT_RESET     = 300;
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_LENGTH = 2'd0,
        REG_LINE_COUNT  = 2'd1
    } cfg_reg_t;

    function automatic int clamp_dim(input int v, input int hi);
        if (v < MIN_DIM)
        begin
            return MIN_DIM;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // B3/S23 on a 3x3 window, bit 4 is the center cell
    function automatic logic life_rule(input logic [8:0] w);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < 9; k++)
        begin
            if (k != 4)
            begin
                n = n + {3'b000, w[k]};
            end
        end
        return (n == 4'(BIRTH_COUNT)) || (w[4] && (n == 4'(SURVIVE_COUNT)));
    endfunction

endpackage

// File: sv/lgs_if.sv
interface lgs_in_if;
    logic valid;
    logic ready;
    logic cell_alive;
    logic drain;

    modport source (output valid, output cell_alive, output drain, input ready);
    modport sink   (input valid, input cell_alive, input drain, output ready);
endinterface

interface lgs_out_if;
    logic valid;
    logic ready;
    logic next_alive;
    logic frame_last;

    modport source (output valid, output next_alive, output frame_last, input ready);
    modport sink   (input valid, input next_alive, input frame_last, output ready);
endinterface

interface lgs_cfg_if import lgs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/life_generation_stencil.sv
// Conway Life (B3/S23) generation over a raster-streamed board.
// cells: one word per cell in storage order, fast index first. drain words
//   after the frame count as dead cells and flush the remaining results.
// results: one word per board cell, next_alive plus frame_last on the last.
// cfg: index 0 = line_length, index 1 = line_count; values are clamped to
//   3..LINE_LEN and 3..NUM_LINES. A write to either restarts the frame. Always ready.
// Throughput: one word per cycle unless a receiver stall drops cells.ready.
//   A cell's result comes out on the word line_length+1 words later: that
//   word's line store read, then window/rule into the output register.
// The two previous lines live in one 2-bit wide line store, read when a
//   word is taken and written back when it leaves the window stage.
// Send line_length+1 drain words after the last cell; the word after the
//   one carrying frame_last starts a new frame.
// Reset: line_length 150, line_count 300 (clamped), frame restarts. Line
//   store contents are never trusted before they are written in the frame.
// Receiver stall: the output register holds; the window stage holds one
//   more word, then cells.ready drops.
module life_generation_stencil import lgs_pkg::*;
#(
    parameter int LINE_LEN  = 256,
    parameter int NUM_LINES = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    lgs_cfg_if.sink     cfg,
    lgs_in_if.sink      cells,
    lgs_out_if.source   results
);

    localparam int PW = $clog2(LINE_LEN);
    localparam int LW = $clog2(LINE_LEN + 1);
    localparam int CW = $clog2(NUM_LINES + 1);
    localparam int RW = $clog2(NUM_LINES + 2);

    localparam logic [LW-1:0] LEN_RST = LW'(clamp_dim(LEN_RESET, LINE_LEN));
    localparam logic [CW-1:0] CNT_RST = CW'(clamp_dim(CNT_RESET, NUM_LINES));

    logic [LW-1:0] len_reg,  len_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic [PW-1:0] pos_reg,  pos_next;
    logic [RW-1:0] line_reg, line_next;

    logic s1_valid_reg, s1_valid_next;
    logic [PW-1:0] s1_pos_reg;
    logic s1_alive_reg, s1_ge1_reg, s1_ge2_reg, s1_first_reg, s1_emit_reg, s1_last_reg;

    logic [8:0] win_reg, win_next;
    logic out_valid_reg, out_valid_next;
    logic out_alive_reg, out_last_reg;

    logic [1:0] line_mem [LINE_LEN];
    logic [1:0] rd_reg;

    logic cfg_wr, restart;
    logic acc, pos_last;
    logic a_alive, a_ge1, a_ge2, a_first, a_emit, a_last;
    logic s1_retire;
    logic top, mid;
    logic [2:0] col;
    logic [8:0] shifted, center, win_upd;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    // config decode
    always_comb
    begin
        len_next = len_reg;
        cnt_next = cnt_reg;
        restart  = 1'b0;
        if (cfg_wr)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_LINE_LENGTH:
                begin
                    len_next = LW'(clamp_dim(int'(cfg.data[LEN_FIELD_W-1:0]), LINE_LEN));
                    restart  = 1'b1;
                end
                REG_LINE_COUNT:
                begin
                    cnt_next = CW'(clamp_dim(int'(cfg.data[CNT_FIELD_W-1:0]), NUM_LINES));
                    restart  = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // input side
    assign s1_retire   = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || results.ready);
    assign cells.ready = !s1_valid_reg || s1_retire;
    assign acc         = cells.valid && cells.ready;

    assign pos_last = (LW'(pos_reg) + LW'(1)) == len_reg;
    assign a_alive  = cells.cell_alive && !cells.drain && (line_reg < RW'(cnt_reg));
    assign a_ge1    = line_reg != '0;
    assign a_ge2    = line_reg > RW'(1);
    assign a_first  = pos_reg == '0;
    assign a_emit   = a_ge2 || (a_ge1 && !a_first);
    assign a_last   = (line_reg == (RW'(cnt_reg) + RW'(1))) && a_first;

    always_comb
    begin
        pos_next  = pos_reg;
        line_next = line_reg;
        if (restart)
        begin
            pos_next  = '0;
            line_next = '0;
        end
        else if (acc)
        begin
            if (a_last)
            begin
                pos_next  = '0;
                line_next = '0;
            end
            else if (pos_last)
            begin
                pos_next  = '0;
                line_next = line_reg + RW'(1);
            end
            else
            begin
                pos_next = pos_reg + PW'(1);
            end
        end
    end

    // window stage
    assign top     = rd_reg[1] && s1_ge2_reg;
    assign mid     = rd_reg[0] && s1_ge1_reg;
    assign col     = {s1_alive_reg, mid, top};
    assign shifted = {col, win_reg[8:3]};

    always_comb
    begin
        if (s1_first_reg)
        begin
            // previous line closes with a dead column
            center  = {3'b000, win_reg[8:3]};
            win_upd = {col, 6'b000000};
        end
        else
        begin
            center  = shifted;
            win_upd = shifted;
        end

        win_next = win_reg;
        if (restart)
        begin
            win_next = '0;
        end
        else if (s1_retire)
        begin
            win_next = s1_last_reg ? 9'b0 : win_upd;
        end

        s1_valid_next = s1_valid_reg;
        if (acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_retire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_retire && s1_emit_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // line store: entry[0] previous line, entry[1] the one before
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rd_reg <= line_mem[pos_reg];
        end
        if (s1_retire)
        begin
            line_mem[s1_pos_reg] <= {mid, s1_alive_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_RST;
            cnt_reg       <= CNT_RST;
            pos_reg       <= '0;
            line_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            line_reg      <= line_next;
            s1_valid_reg  <= s1_valid_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pos_reg   <= pos_reg;
            s1_alive_reg <= a_alive;
            s1_ge1_reg   <= a_ge1;
            s1_ge2_reg   <= a_ge2;
            s1_first_reg <= a_first;
            s1_emit_reg  <= a_emit;
            s1_last_reg  <= a_last;
        end
        if (s1_retire && s1_emit_reg)
        begin
            out_alive_reg <= life_rule(center);
            out_last_reg  <= s1_last_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.next_alive = out_alive_reg;
    assign results.frame_last = out_last_reg;

    a_pos_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(pos_reg) < len_reg)
        else $error("position beyond line length");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg >= LW'(MIN_DIM)) && (len_reg <= LW'(LINE_LEN)))
        else $error("line length out of range");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && a_last && !restart) |=> (pos_reg == '0) && (line_reg == '0))
        else $error("frame did not restart after last word");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg) |-> s1_emit_reg)
        else $error("frame end without result");

endmodule
